>>> rtl/version_constraint_text_parser_top_macros.svh
// Assertion macros shared by the version constraint parser RTL.
`ifndef VERSION_CONSTRAINT_TEXT_PARSER_TOP_MACROS_SVH
`define VERSION_CONSTRAINT_TEXT_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge outside reset.
`define VCTP_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a trigger is followed by a consequence on the next edge.
`define VCTP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`else

`define VCTP_ASSERT(lbl, clk, rst_n, cond)
`define VCTP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)

`endif

`endif

>>> rtl/vctp_pkg.sv
// Types and constants of the version constraint parser.
package vctp_pkg;

  parameter int MAX_TEXT_LENGTH  = 256;
  parameter int MAX_TOKEN_LENGTH = 64;
  parameter int MAX_COMPONENTS   = 8;
  parameter int MAX_COMPARISONS  = 8;

  // Output field widths are fixed by the interface.
  parameter int OFS_W = 9;
  parameter int IDX_W = 3;
  parameter int VAL_W = 32;
  parameter int DIG_W = 7;

  parameter int CMP_CNT_W  = $clog2(MAX_COMPARISONS + 1);
  parameter int COMP_CNT_W = $clog2(MAX_COMPONENTS + 1);

  // Result queue; depth must be a power of two of at least 2.
  parameter int FIFO_DEPTH = 4;
  parameter int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  parameter int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  parameter logic [7:0] CH_SPACE = 8'h20;
  parameter logic [7:0] CH_TAB   = 8'h09;
  parameter logic [7:0] CH_CR    = 8'h0D;
  parameter logic [7:0] CH_DOT   = 8'h2E;
  parameter logic [7:0] CH_ZERO  = 8'h30;
  parameter logic [7:0] CH_NINE  = 8'h39;
  parameter logic [7:0] CH_LT    = 8'h3C;
  parameter logic [7:0] CH_GT    = 8'h3E;
  parameter logic [7:0] CH_EQ    = 8'h3D;
  parameter logic [7:0] CH_BANG  = 8'h21;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_EMPTY       = 4'd1,
    ST_LENGTH      = 4'd2,
    ST_EMPTY_COMP  = 4'd3,
    ST_LEAD_ZERO   = 4'd4,
    ST_BAD_CHAR    = 4'd5,
    ST_COMPONENTS  = 4'd6,
    ST_OVERFLOW    = 4'd7,
    ST_MISSING     = 4'd8,
    ST_BAD_OP      = 4'd9,
    ST_COMPARISONS = 4'd10
  } status_t;

  typedef enum logic [2:0] {
    OP_EXACT      = 3'd0,
    OP_LESS       = 3'd1,
    OP_LESS_EQ    = 3'd2,
    OP_GREATER    = 3'd3,
    OP_GREATER_EQ = 3'd4
  } op_t;

  typedef enum logic {
    KIND_COMPONENT = 1'b0,
    KIND_STATUS    = 1'b1
  } kind_t;

  typedef struct packed {
    logic              item_kind;
    logic [IDX_W-1:0]  comparison_index;
    logic [2:0]        operator_code;
    logic [IDX_W-1:0]  component_index;
    logic [VAL_W-1:0]  component_value;
    logic [3:0]        status_code;
    logic [OFS_W-1:0]  error_offset;
    logic              final_flag;
  } res_t;

  // Up to two words per accepted byte: a finished component, then the status.
  typedef struct packed {
    logic comp_v;
    logic stat_v;
    res_t comp;
    res_t stat;
  } push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> rtl/vctp_core.sv
// Byte-at-a-time parse state and result word generation.
module vctp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           char_code,
  input  logic                 is_last,
  input  logic                 void_text,
  output vctp_pkg::push_t      push
);
  import vctp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD       = 3'd0,
    PH_OP1        = 3'd1,
    PH_OP2        = 3'd2,
    PH_TOKEN      = 3'd3,
    PH_GAP        = 3'd4,
    PH_HALT_TOKEN = 3'd5,
    PH_HALT       = 3'd6
  } phase_t;

  phase_t                 phase_r,  phase_nxt;
  logic [OFS_W-1:0]       bpos_r,   bpos_nxt;
  logic [CMP_CNT_W-1:0]   ccnt_r,   ccnt_nxt;
  logic [COMP_CNT_W-1:0]  kcnt_r,   kcnt_nxt;
  logic [VAL_W-1:0]       acc_r,    acc_nxt;
  logic [DIG_W-1:0]       dcnt_r,   dcnt_nxt;
  logic                   fdz_r,    fdz_nxt;
  logic [OFS_W-1:0]       tstart_r, tstart_nxt;
  op_t                    op_r,     op_nxt;
  status_t                err_r,    err_nxt;
  logic [OFS_W-1:0]       eofs_r,   eofs_nxt;
  logic                   eit_r,    eit_nxt;

  logic [OFS_W-1:0]       pos;
  logic [OFS_W-1:0]       tlen;
  logic                   do_tok;
  logic                   ws;
  logic [3:0]             dig;
  logic [VAL_W+3:0]       prod;

  always_comb begin
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    ccnt_nxt   = ccnt_r;
    kcnt_nxt   = kcnt_r;
    acc_nxt    = acc_r;
    dcnt_nxt   = dcnt_r;
    fdz_nxt    = fdz_r;
    tstart_nxt = tstart_r;
    op_nxt     = op_r;
    err_nxt    = err_r;
    eofs_nxt   = eofs_r;
    eit_nxt    = eit_r;
    push       = '0;
    pos        = bpos_r;
    do_tok     = 1'b0;
    ws         = is_ws(char_code);
    dig        = char_code[3:0];
    tlen       = '0;
    prod       = '0;

    if (take && !void_text) begin
      if (32'(pos) >= MAX_TEXT_LENGTH) begin
        // overlong text beats everything seen before
        err_nxt   = ST_LENGTH;
        eofs_nxt  = OFS_W'(MAX_TEXT_LENGTH);
        eit_nxt   = 1'b0;
        phase_nxt = PH_HALT;
      end else begin
        bpos_nxt = pos + OFS_W'(1);
        unique case (phase_r)
          PH_LEAD, PH_GAP: begin
            if (!ws) begin
              if (32'(ccnt_r) >= MAX_COMPARISONS) begin
                if (err_nxt == ST_OK) begin
                  err_nxt  = ST_COMPARISONS;
                  eofs_nxt = pos;
                  eit_nxt  = 1'b0;
                end
                phase_nxt = PH_HALT;
              end else if (char_code == CH_LT || char_code == CH_GT) begin
                op_nxt    = (char_code == CH_LT) ? OP_LESS : OP_GREATER;
                phase_nxt = PH_OP1;
              end else if (char_code == CH_EQ || char_code == CH_BANG) begin
                if (err_nxt == ST_OK) begin
                  err_nxt  = ST_BAD_OP;
                  eofs_nxt = pos;
                  eit_nxt  = 1'b0;
                end
                phase_nxt = PH_HALT;
              end else begin
                op_nxt = OP_EXACT;
                do_tok = 1'b1;
              end
            end
          end
          PH_OP1, PH_OP2: begin
            if (phase_r == PH_OP1 && char_code == CH_EQ) begin
              op_nxt    = (op_r == OP_LESS) ? OP_LESS_EQ : OP_GREATER_EQ;
              phase_nxt = PH_OP2;
            end else if (ws) begin
              if (err_nxt == ST_OK) begin
                err_nxt  = ST_MISSING;
                eofs_nxt = pos;
                eit_nxt  = 1'b0;
              end
              phase_nxt = PH_HALT;
            end else begin
              do_tok = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (ws) begin
              // whitespace closes the last component of the version
              if (dcnt_nxt == '0) begin
                if (err_nxt == ST_OK) begin
                  err_nxt  = ST_EMPTY_COMP;
                  eofs_nxt = pos;
                  eit_nxt  = 1'b1;
                end
              end else if (err_nxt == ST_OK) begin
                push.comp_v                = 1'b1;
                push.comp.comparison_index = IDX_W'(ccnt_nxt);
                push.comp.operator_code    = op_nxt;
                push.comp.component_index  = IDX_W'(kcnt_nxt);
                push.comp.component_value  = acc_nxt;
                kcnt_nxt                   = kcnt_nxt + COMP_CNT_W'(1);
              end
              if (err_nxt != ST_OK) begin
                phase_nxt = PH_HALT;
              end else begin
                ccnt_nxt  = ccnt_nxt + CMP_CNT_W'(1);
                phase_nxt = PH_GAP;
              end
            end else begin
              do_tok = 1'b1;
            end
          end
          PH_HALT_TOKEN: begin
            if (ws) phase_nxt = PH_HALT;
            else    do_tok    = 1'b1;
          end
          default: begin
          end
        endcase

        // Open a new version token when leaving the whitespace or operator phases.
        if (do_tok && (phase_r != PH_TOKEN) && (phase_r != PH_HALT_TOKEN)) begin
          tstart_nxt = pos;
          kcnt_nxt   = '0;
          acc_nxt    = '0;
          dcnt_nxt   = '0;
          fdz_nxt    = 1'b0;
          phase_nxt  = PH_TOKEN;
        end

        if (do_tok) begin
          tlen = pos - tstart_nxt;
          if (32'(tlen) >= MAX_TOKEN_LENGTH) begin
            // overlong version beats errors inside it, not earlier ones
            if (err_nxt == ST_OK || eit_nxt) begin
              err_nxt  = ST_LENGTH;
              eofs_nxt = OFS_W'(32'(tstart_nxt) + MAX_TOKEN_LENGTH);
              eit_nxt  = 1'b0;
            end
            phase_nxt = PH_HALT;
          end else if (phase_nxt != PH_HALT_TOKEN) begin
            if (char_code == CH_DOT) begin
              if (dcnt_nxt == '0) begin
                if (err_nxt == ST_OK) begin
                  err_nxt  = ST_EMPTY_COMP;
                  eofs_nxt = pos;
                  eit_nxt  = 1'b1;
                end
              end else if (err_nxt == ST_OK) begin
                push.comp_v                = 1'b1;
                push.comp.comparison_index = IDX_W'(ccnt_nxt);
                push.comp.operator_code    = op_nxt;
                push.comp.component_index  = IDX_W'(kcnt_nxt);
                push.comp.component_value  = acc_nxt;
                kcnt_nxt                   = kcnt_nxt + COMP_CNT_W'(1);
              end
              if (err_nxt == ST_OK && 32'(kcnt_nxt) >= MAX_COMPONENTS) begin
                err_nxt  = ST_COMPONENTS;
                eofs_nxt = pos + OFS_W'(1);
                eit_nxt  = 1'b1;
              end
              acc_nxt  = '0;
              dcnt_nxt = '0;
              fdz_nxt  = 1'b0;
            end else if (dcnt_nxt != '0 && fdz_nxt) begin
              if (err_nxt == ST_OK) begin
                err_nxt  = ST_LEAD_ZERO;
                eofs_nxt = pos - OFS_W'(dcnt_nxt);
                eit_nxt  = 1'b1;
              end
            end else if (char_code < CH_ZERO || char_code > CH_NINE) begin
              if (err_nxt == ST_OK) begin
                err_nxt  = ST_BAD_CHAR;
                eofs_nxt = pos;
                eit_nxt  = 1'b1;
              end
            end else begin
              // acc * 10 + digit, with carry-out as overflow
              prod = {1'b0, acc_nxt, 3'b000} + {3'b000, acc_nxt, 1'b0}
                   + (VAL_W+4)'(dig);
              if (prod[VAL_W+3:VAL_W] != '0) begin
                if (err_nxt == ST_OK) begin
                  err_nxt  = ST_OVERFLOW;
                  eofs_nxt = pos;
                  eit_nxt  = 1'b1;
                end
              end else begin
                acc_nxt = prod[VAL_W-1:0];
                if (dcnt_nxt == '0) fdz_nxt = (dig == 4'd0);
                if (dcnt_nxt != '1) dcnt_nxt = dcnt_nxt + DIG_W'(1);
              end
            end
            if (err_nxt != ST_OK) phase_nxt = PH_HALT_TOKEN;
          end
        end
      end
    end

    if (take && is_last) begin
      if (err_nxt == ST_OK) begin
        if (phase_nxt == PH_LEAD) begin
          err_nxt  = ST_EMPTY;
          eofs_nxt = bpos_nxt;
        end else if (phase_nxt == PH_OP1 || phase_nxt == PH_OP2) begin
          err_nxt  = ST_MISSING;
          eofs_nxt = bpos_nxt;
        end else if (phase_nxt == PH_TOKEN) begin
          if (dcnt_nxt == '0) begin
            err_nxt  = ST_EMPTY_COMP;
            eofs_nxt = bpos_nxt;
          end else begin
            push.comp_v                = 1'b1;
            push.comp.comparison_index = IDX_W'(ccnt_nxt);
            push.comp.operator_code    = op_nxt;
            push.comp.component_index  = IDX_W'(kcnt_nxt);
            push.comp.component_value  = acc_nxt;
          end
        end
      end
      push.stat_v            = 1'b1;
      push.stat.item_kind    = KIND_STATUS;
      push.stat.status_code  = err_nxt;
      push.stat.error_offset = (err_nxt == ST_OK) ? '0 : eofs_nxt;
      push.stat.final_flag   = 1'b1;

      // back to the reset state for the next text
      phase_nxt  = PH_LEAD;
      bpos_nxt   = '0;
      ccnt_nxt   = '0;
      kcnt_nxt   = '0;
      acc_nxt    = '0;
      dcnt_nxt   = '0;
      fdz_nxt    = 1'b0;
      tstart_nxt = '0;
      op_nxt     = OP_EXACT;
      err_nxt    = ST_OK;
      eofs_nxt   = '0;
      eit_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      bpos_r   <= '0;
      ccnt_r   <= '0;
      kcnt_r   <= '0;
      acc_r    <= '0;
      dcnt_r   <= '0;
      fdz_r    <= 1'b0;
      tstart_r <= '0;
      op_r     <= OP_EXACT;
      err_r    <= ST_OK;
      eofs_r   <= '0;
      eit_r    <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      bpos_r   <= bpos_nxt;
      ccnt_r   <= ccnt_nxt;
      kcnt_r   <= kcnt_nxt;
      acc_r    <= acc_nxt;
      dcnt_r   <= dcnt_nxt;
      fdz_r    <= fdz_nxt;
      tstart_r <= tstart_nxt;
      op_r     <= op_nxt;
      err_r    <= err_nxt;
      eofs_r   <= eofs_nxt;
      eit_r    <= eit_nxt;
    end
  end

endmodule

>>> rtl/vctp_fifo.sv
// Small result queue taking up to two words per cycle and giving one.
module vctp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  vctp_pkg::push_t  push,
  input  logic             pop,
  output logic             room,
  output logic             head_valid,
  output vctp_pkg::res_t   head
);
  import vctp_pkg::*;

  res_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_r, wr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FIFO_PTR_W-1:0]  wr_p1;
  logic [1:0]             n_push;
  logic                   do_pop;
  res_t                   d0;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  // Hold room for a component word plus a status word.
  assign room       = (32'(cnt_r) <= FIFO_DEPTH - 2);
  assign do_pop     = pop && head_valid;
  assign n_push     = 2'(push.comp_v) + 2'(push.stat_v);
  assign d0         = push.comp_v ? push.comp : push.stat;
  assign wr_p1      = wr_r + FIFO_PTR_W'(1);
  assign wr_nxt     = wr_r + FIFO_PTR_W'(n_push);
  assign rd_nxt     = do_pop ? rd_r + FIFO_PTR_W'(1) : rd_r;
  assign cnt_nxt    = cnt_r + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r]  <= d0;
    if (n_push == 2'd2) mem_r[wr_p1] <= push.stat;
  end

endmodule

>>> rtl/version_constraint_text_parser_top.sv
// Top level of the streaming version constraint parser.
//
//  channel | ports                                   | dir | one word is
//  --------+-----------------------------------------+-----+---------------------------------
//  in      | in_valid/in_ready, in_char_code, ...    | in  | one text byte, last or void mark
//  out     | out_valid/out_ready, out_item_kind, ... | out | one component or the final status
//
//  Every accepted byte is parsed in the cycle it is accepted: one multiply-by-ten-and-add
//  on the component accumulator plus the phase update, so one byte per cycle is sustained.
//  A byte yields up to two words (a finished component, then the status on the last byte);
//  they land in a four-word result queue and leave one per cycle, first word the next cycle.
//  in_ready drops while fewer than two queue slots are free: under out_ready stalls, or
//  after back-to-back last bytes that each add two words. rst_n is synchronous: it clears
//  the parse state and empties the queue.
`include "version_constraint_text_parser_top_macros.svh"

module version_constraint_text_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_is_last,
  input  logic                        in_void_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_item_kind,
  output logic [vctp_pkg::IDX_W-1:0]  out_comparison_index,
  output logic [2:0]                  out_operator_code,
  output logic [vctp_pkg::IDX_W-1:0]  out_component_index,
  output logic [vctp_pkg::VAL_W-1:0]  out_component_value,
  output logic [3:0]                  out_status_code,
  output logic [vctp_pkg::OFS_W-1:0]  out_error_offset,
  output logic                        out_final_flag
);
  import vctp_pkg::*;

  logic   take;
  logic   room;
  push_t  push;
  res_t   head;

  // Accept a byte whenever the queue can absorb a worst-case pair of words.
  assign in_ready = room;
  assign take     = in_valid && room;

  vctp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .void_text (in_void_text),
    .push      (push)
  );

  vctp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_ready),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  // Drive the result word straight from the queue head.
  assign out_item_kind        = head.item_kind;
  assign out_comparison_index = head.comparison_index;
  assign out_operator_code    = head.operator_code;
  assign out_component_index  = head.component_index;
  assign out_component_value  = head.component_value;
  assign out_status_code      = head.status_code;
  assign out_error_offset     = head.error_offset;
  assign out_final_flag       = head.final_flag;

  // A last byte always leaves a status word waiting on the next edge.
  `VCTP_ASSERT_NEXT(a_last_gives_word, clk, rst_n, in_valid && in_ready && in_is_last, out_valid)
  // The final flag appears only on status words.
  `VCTP_ASSERT(a_final_is_status, clk, rst_n, !out_valid || !out_final_flag || out_item_kind)
  // Component words carry no status and no offset.
  `VCTP_ASSERT(a_comp_no_status, clk, rst_n, !out_valid || out_item_kind || out_status_code == ST_OK)
  `VCTP_ASSERT(a_comp_no_offset, clk, rst_n, !out_valid || out_item_kind || out_error_offset == '0)

endmodule
